[sv/amatinv_pkg.sv]
// amatinv_pkg: shared constants of the affine matrix inverse block
// no dependencies; imported by the front, back and top-level modules
package amatinv_pkg;

  // elements of one input transform (three linear groups plus translation)
  localparam int N_ELEM = 12;
  // numerators per transform, and record entries (numerators plus determinant)
  localparam int N_NUM = 12;
  localparam int N_REC = 13;

  // result group codes
  localparam logic [1:0] GRP_FIRST = 2'd0;
  localparam logic [1:0] GRP_TRANS = 2'd3;

endpackage

[sv/amatinv_queue.sv]
// amatinv_queue: two-entry queue with push/full and pop/empty sides
// no dependencies; used between front and back and at the result side
module amatinv_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[sv/amatinv_front.sv]
// amatinv_front: takes a request and forms the twelve exact numerators and the
// determinant with one shared multiplier under a fixed step sequence; uses amatinv_pkg
module amatinv_front
  import amatinv_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_W      = 99
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [N_ELEM*DATA_WIDTH-1:0]   mat,
  output logic                           rec_push,
  input  logic                           rec_full,
  output logic [N_REC*NUM_W-1:0]         rec
);

  localparam int         N_SLOT = 19;
  localparam logic [5:0] NSTEP  = 6'd54;
  localparam logic [5:0] NARROW = 6'd30;

  localparam logic [1:0] BK_IN = 2'd0;
  localparam logic [1:0] BK_LO = 2'd1;
  localparam logic [1:0] BK_HI = 2'd2;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [1:0] b_kind;
    logic [4:0] b_sel;
    logic       sub;
    logic       first;
    logic       last;
    logic [4:0] dest;
  } uop_t;

  // 2x2 cofactors: {a1, b1, a2, b2}, value a1*b1 - a2*b2
  // elements a..l are 0..11; cofactors 9..14 are the translation helpers
  function automatic logic [15:0] narrow_pair(input logic [4:0] p);
    logic [15:0] r;
    begin
      unique case (p)
        5'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
        5'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
        5'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
        5'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
        5'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
        5'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
        5'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
        5'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
        5'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
        5'd9:    r = {4'd6, 4'd11, 4'd8, 4'd9};
        5'd10:   r = {4'd7, 4'd9, 4'd6, 4'd10};
        5'd11:   r = {4'd7, 4'd11, 4'd8, 4'd10};
        5'd12:   r = {4'd3, 4'd11, 4'd5, 4'd9};
        5'd13:   r = {4'd4, 4'd9, 4'd3, 4'd10};
        5'd14:   r = {4'd4, 4'd11, 4'd5, 4'd10};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // wide terms: {a, slot, sub, first, last, dest}
  function automatic logic [16:0] wide_term(input logic [4:0] t);
    logic [16:0] r;
    begin
      unique case (t)
        5'd0:    r = {4'd0, 5'd0,  1'b0, 1'b1, 1'b0, 5'd12};
        5'd1:    r = {4'd1, 5'd3,  1'b0, 1'b0, 1'b0, 5'd12};
        5'd2:    r = {4'd2, 5'd6,  1'b0, 1'b0, 1'b1, 5'd12};
        5'd3:    r = {4'd4, 5'd13, 1'b0, 1'b1, 1'b0, 5'd9};
        5'd4:    r = {4'd5, 5'd14, 1'b0, 1'b0, 1'b0, 5'd9};
        5'd5:    r = {4'd3, 5'd15, 1'b1, 1'b0, 1'b1, 5'd9};
        5'd6:    r = {4'd0, 5'd15, 1'b0, 1'b1, 1'b0, 5'd10};
        5'd7:    r = {4'd1, 5'd13, 1'b1, 1'b0, 1'b0, 5'd10};
        5'd8:    r = {4'd2, 5'd14, 1'b1, 1'b0, 1'b1, 5'd10};
        5'd9:    r = {4'd1, 5'd16, 1'b0, 1'b1, 1'b0, 5'd11};
        5'd10:   r = {4'd2, 5'd17, 1'b0, 1'b0, 1'b0, 5'd11};
        5'd11:   r = {4'd0, 5'd18, 1'b1, 1'b0, 1'b1, 5'd11};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // step decode: cofactor products first, then the wide products in halves
  function automatic uop_t ucode(input logic [5:0] s);
    uop_t        u;
    logic [15:0] pr;
    logic [16:0] wt;
    logic [5:0]  w;
    logic [4:0]  p;
    begin
      u = '0;
      if (s < NARROW) begin
        p        = s[5:1];
        pr       = narrow_pair(p);
        u.a_sel  = s[0] ? pr[7:4] : pr[15:12];
        u.b_sel  = {1'b0, (s[0] ? pr[3:0] : pr[11:8])};
        u.b_kind = BK_IN;
        u.sub    = s[0];
        u.first  = !s[0];
        u.last   = s[0];
        u.dest   = (p < 5'd9) ? p : p + 5'd4;
      end else begin
        w        = s - NARROW;
        wt       = wide_term(w[5:1]);
        u.a_sel  = wt[16:13];
        u.b_sel  = wt[12:8];
        u.b_kind = w[0] ? BK_LO : BK_HI;
        u.sub    = wt[7];
        u.first  = wt[6] && !w[0];
        u.last   = wt[5] && w[0];
        u.dest   = wt[4:0];
      end
      return u;
    end
  endfunction

  logic [N_ELEM*DATA_WIDTH-1:0] mat_r;
  logic                         busy_r, busy_nxt;
  logic [5:0]                   step_r, step_nxt;
  logic                         issue;
  logic                         done;
  uop_t                         uop;
  logic signed [DATA_WIDTH-1:0] opa;
  logic signed [DATA_WIDTH:0]   opb;
  logic signed [2*DATA_WIDTH:0] prod;
  logic signed [2*DATA_WIDTH:0] mul_r;
  uop_t                         mctl_r;
  logic                         mv_r;
  logic signed [NUM_W-1:0]      addend;
  logic signed [NUM_W-1:0]      acc_r, acc_nxt;
  logic signed [NUM_W-1:0]      slot_r [N_SLOT];

  assign full     = busy_r;
  assign issue    = busy_r && (step_r != NSTEP);
  assign done     = busy_r && (step_r == NSTEP) && !mv_r;
  assign rec_push = done;

  // sequencer control
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (push && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (issue) begin
      step_nxt = step_r + 6'd1;
    end else if (done && !rec_full) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      mv_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      mv_r   <= issue;
    end
  end

  // operand selection and multiply
  always_comb begin
    uop = ucode(step_r);
    opa = mat_r[uop.a_sel*DATA_WIDTH +: DATA_WIDTH];
    unique case (uop.b_kind)
      BK_IN:   opb = (DATA_WIDTH+1)'(signed'(mat_r[uop.b_sel[3:0]*DATA_WIDTH +: DATA_WIDTH]));
      BK_LO:   opb = {1'b0, slot_r[uop.b_sel][DATA_WIDTH-1:0]};
      BK_HI:   opb = slot_r[uop.b_sel][2*DATA_WIDTH:DATA_WIDTH];
      default: opb = '0;
    endcase
    prod = opa * opb;
  end

  always_ff @(posedge clk) begin
    if (push && !busy_r) begin
      mat_r <= mat;
    end
    mul_r  <= prod;
    mctl_r <= uop;
  end

  // accumulate and store finished sums
  always_comb begin
    addend = NUM_W'(mul_r);
    if (mctl_r.b_kind == BK_HI) begin
      addend = addend <<< DATA_WIDTH;
    end
    acc_nxt = (mctl_r.first ? '0 : acc_r) + (mctl_r.sub ? -addend : addend);
  end

  always_ff @(posedge clk) begin
    if (mv_r) begin
      acc_r <= acc_nxt;
      if (mctl_r.last) begin
        slot_r[mctl_r.dest] <= acc_nxt;
      end
    end
  end

  // record: numerators 0..11 then the determinant
  always_comb begin
    for (int m = 0; m < N_REC; m++) begin
      rec[m*NUM_W +: NUM_W] = slot_r[m];
    end
  end

endmodule

[sv/amatinv_div.sv]
// amatinv_div: rounded, saturated quotient (num << s) / den, one bit a cycle
// no dependencies; instantiated three times by amatinv_back
module amatinv_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int NUM_W      = 99
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         trans,
  input  logic signed [NUM_W-1:0]      num,
  input  logic signed [NUM_W-1:0]      den,
  output logic                         busy,
  output logic signed [DATA_WIDTH-1:0] quo
);

  localparam int QB    = DATA_WIDTH + 1;
  localparam int QW    = QB + 1;
  localparam int DV_W  = NUM_W + 2*FRAC_BITS + DATA_WIDTH + 2;
  localparam int CNT_W = $clog2(QW + 1);

  logic [NUM_W-1:0] mag_n, mag_d;
  logic [DV_W-1:0]  n_sh;
  logic [DV_W-1:0]  r_r, r_nxt;
  logic [DV_W-1:0]  ys_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             neg_r;
  logic             ge;
  logic [QW-1:0]    lim;
  logic [QW-1:0]    mag_q;

  assign busy = run_r;

  // magnitudes and scaled dividend
  always_comb begin
    mag_n = num[NUM_W-1] ? -num : num;
    mag_d = den[NUM_W-1] ? -den : den;
    n_sh  = trans ? (DV_W'(mag_n) << FRAC_BITS) : (DV_W'(mag_n) << (2*FRAC_BITS));
  end

  // restoring step
  always_comb begin
    ge    = (r_r >= ys_r);
    r_nxt = ge ? r_r - ys_r : r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(QW);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // datapath: dividend 2N+D over divisor 2D gives round half away from zero
  always_ff @(posedge clk) begin
    if (start) begin
      r_r   <= (n_sh << 1) + DV_W'(mag_d);
      ys_r  <= DV_W'(mag_d) << (QB + 1);
      q_r   <= '0;
      neg_r <= num[NUM_W-1] ^ den[NUM_W-1];
    end else if (run_r) begin
      r_r  <= r_nxt;
      ys_r <= ys_r >> 1;
      q_r  <= {q_r[QW-2:0], ge};
    end
  end

  // saturation and sign
  always_comb begin
    lim   = neg_r ? (QW'(1) << (DATA_WIDTH-1)) : ((QW'(1) << (DATA_WIDTH-1)) - QW'(1));
    mag_q = (q_r > lim) ? lim : q_r;
    quo   = neg_r ? DATA_WIDTH'(~mag_q + QW'(1)) : DATA_WIDTH'(mag_q);
  end

endmodule

[sv/amatinv_back.sv]
// amatinv_back: takes numerator records and divides each group by the
// determinant on three divider lanes; uses amatinv_pkg and amatinv_div
module amatinv_back
  import amatinv_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int NUM_W      = 99
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rec_empty,
  output logic                      rec_pop,
  input  logic [N_REC*NUM_W-1:0]    rec,
  output logic                      item_push,
  input  logic                      item_full,
  output logic [3*DATA_WIDTH+3:0]   item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                   st_r, st_nxt;
  logic [1:0]                   grp_r, grp_nxt;
  logic [N_REC*NUM_W-1:0]       rec_r;
  logic                         start;
  logic                         trans;
  logic                         sing;
  logic signed [NUM_W-1:0]      det;
  logic [2:0]                   busy;
  logic signed [DATA_WIDTH-1:0] quo [3];
  logic [DATA_WIDTH-1:0]        val [3];

  assign det       = rec_r[N_NUM*NUM_W +: NUM_W];
  assign sing      = (det == '0);
  assign trans     = (grp_r == GRP_TRANS);
  assign start     = (st_r == ST_START);
  assign rec_pop   = (st_r == ST_IDLE) && !rec_empty;
  assign item_push = (st_r == ST_EMIT);

  // group sequencing
  always_comb begin
    st_nxt  = st_r;
    grp_nxt = grp_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!rec_empty) begin
          st_nxt  = ST_START;
          grp_nxt = GRP_FIRST;
        end
      end
      ST_START: st_nxt = ST_RUN;
      ST_RUN: begin
        if (busy == 3'b000) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!item_full) begin
          if (trans) begin
            st_nxt = ST_IDLE;
          end else begin
            st_nxt  = ST_START;
            grp_nxt = grp_r + 2'd1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      grp_r <= GRP_FIRST;
    end else begin
      st_r  <= st_nxt;
      grp_r <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      rec_r <= rec;
    end
  end

  // divider lanes, one per element of the group
  for (genvar k = 0; k < 3; k++) begin : g_lane
    amatinv_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .NUM_W      (NUM_W)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start),
      .trans (trans),
      .num   (rec_r[(int'(grp_r)*3 + k)*NUM_W +: NUM_W]),
      .den   (det),
      .busy  (busy[k]),
      .quo   (quo[k])
    );
    assign val[k] = sing ? '0 : quo[k];
  end

  assign item = {grp_r, val[0], val[1], val[2], sing, trans};

endmodule

[sv/affine_matrix_inverse_top.sv]
// affine 3x4 matrix inverse, Q16.16 by default, four result groups per request
// the back works out the result groups one after another on its divider lanes
// throughput is set by the bit-serial divider lanes, not by the front's one multiplier
// the front takes the next request once its record has gone into the middle queue
// reset: synchronous active-low rst_n empties both queues and idles front and back
module affine_matrix_inverse_top
  import amatinv_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] in_col0_x,
  input  logic signed [DATA_WIDTH-1:0] in_col0_y,
  input  logic signed [DATA_WIDTH-1:0] in_col0_z,
  input  logic signed [DATA_WIDTH-1:0] in_col1_x,
  input  logic signed [DATA_WIDTH-1:0] in_col1_y,
  input  logic signed [DATA_WIDTH-1:0] in_col1_z,
  input  logic signed [DATA_WIDTH-1:0] in_col2_x,
  input  logic signed [DATA_WIDTH-1:0] in_col2_y,
  input  logic signed [DATA_WIDTH-1:0] in_col2_z,
  input  logic signed [DATA_WIDTH-1:0] in_trans_x,
  input  logic signed [DATA_WIDTH-1:0] in_trans_y,
  input  logic signed [DATA_WIDTH-1:0] in_trans_z,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   out_group_index,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [DATA_WIDTH-1:0] out_z,
  output logic                         out_singular,
  output logic                         out_last
);

  localparam int NUM_W  = 3*DATA_WIDTH + 3;
  localparam int REC_W  = N_REC*NUM_W;
  localparam int ITEM_W = 3*DATA_WIDTH + 4;

  logic [N_ELEM*DATA_WIDTH-1:0] mat;
  logic                         rec_push, rec_full, rec_empty, rec_pop;
  logic [REC_W-1:0]             rec_in, rec_out;
  logic                         item_push, item_full;
  logic [ITEM_W-1:0]            item_in, item_out;

  assign mat = {in_trans_z, in_trans_y, in_trans_x,
                in_col2_z, in_col2_y, in_col2_x,
                in_col1_z, in_col1_y, in_col1_x,
                in_col0_z, in_col0_y, in_col0_x};

  // front: numerators and determinant
  amatinv_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_W      (NUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .mat      (mat),
    .rec_push (rec_push),
    .rec_full (rec_full),
    .rec      (rec_in)
  );

  // queue between front and back
  amatinv_queue #(
    .W (REC_W)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .full  (rec_full),
    .din   (rec_in),
    .pop   (rec_pop),
    .empty (rec_empty),
    .dout  (rec_out)
  );

  // back: division per group
  amatinv_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .NUM_W      (NUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .rec       (rec_out),
    .item_push (item_push),
    .item_full (item_full),
    .item      (item_in)
  );

  // result queue
  amatinv_queue #(
    .W (ITEM_W)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (item_push),
    .full  (item_full),
    .din   (item_in),
    .pop   (pop),
    .empty (empty),
    .dout  (item_out)
  );

  assign out_group_index = item_out[ITEM_W-1 -: 2];
  assign out_x           = item_out[3*DATA_WIDTH+1 -: DATA_WIDTH];
  assign out_y           = item_out[2*DATA_WIDTH+1 -: DATA_WIDTH];
  assign out_z           = item_out[DATA_WIDTH+1 -: DATA_WIDTH];
  assign out_singular    = item_out[1];
  assign out_last        = item_out[0];

endmodule

[test/affine_matrix_inverse_top_test.sv]
// testbench for affine_matrix_inverse_top: queue-style driver and monitor, exact wide-integer
// inverse predictor, random idling on both sides and one long output hold-off
// depends on amatinv_pkg and affine_matrix_inverse_top
module affine_matrix_inverse_top_test;
  import amatinv_pkg::*;

  localparam int TOTAL_REQ   = 500;
  localparam int QUIET_REQ   = 450;
  localparam int HOLD_CYCLES = 1000;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 400;

  typedef logic signed [31:0] elem_t;
  typedef logic signed [255:0] big_t;
  typedef struct {
    elem_t e[12];
  } matrix_t;
  typedef struct {
    logic [1:0] grp;
    elem_t      x, y, z;
    logic       sing, last;
  } group_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  push = 1'b0;
  logic  pop = 1'b0;
  elem_t in_e[12] = '{default: '0};
  logic  full, empty, out_singular, out_last;
  logic [1:0] out_group_index;
  elem_t out_x, out_y, out_z;

  matrix_t pending_matrices[$];
  group_t  inverse_expect_q[$];
  int      sent_cnt = 0;
  int      recv_cnt = 0;
  int      errors = 0;
  int      tx_gap = 0;
  int      rx_gap = 0;
  int      hold_cnt = 0;
  bit      hold_done = 0;
  int      idle_cycles = 0;

  affine_matrix_inverse_top u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_col0_x(in_e[0]), .in_col0_y(in_e[1]), .in_col0_z(in_e[2]),
    .in_col1_x(in_e[3]), .in_col1_y(in_e[4]), .in_col1_z(in_e[5]),
    .in_col2_x(in_e[6]), .in_col2_y(in_e[7]), .in_col2_z(in_e[8]),
    .in_trans_x(in_e[9]), .in_trans_y(in_e[10]), .in_trans_z(in_e[11]),
    .empty(empty), .pop(pop), .out_group_index(out_group_index),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_singular(out_singular), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // rounded, saturated (num << s) / det, ties away from zero
  function automatic elem_t scaled_quotient(big_t num, big_t det, int s);
    logic [255:0] mn, md, q, lim;
    logic neg;
    neg = num[255] ^ det[255];
    mn = num[255] ? -num : num;
    md = det[255] ? -det : det;
    mn = mn << s;
    q = ((mn << 1) + md) / (md << 1);
    lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic big_t cofactor(big_t p, big_t q, big_t r, big_t t);
    return p * q - r * t;
  endfunction

  // expected four groups of the inverse of one transform
  task automatic predict_inverse(matrix_t m);
    big_t a, b, c, d, e, f, g, h, i, j, k, l, det;
    big_t num[12];
    group_t grp;
    logic sing;
    a = m.e[0]; b = m.e[1]; c = m.e[2];
    d = m.e[3]; e = m.e[4]; f = m.e[5];
    g = m.e[6]; h = m.e[7]; i = m.e[8];
    j = m.e[9]; k = m.e[10]; l = m.e[11];
    num[0] = cofactor(e, i, f, h);
    num[1] = cofactor(c, h, b, i);
    num[2] = cofactor(b, f, c, e);
    num[3] = cofactor(f, g, d, i);
    num[4] = cofactor(a, i, c, g);
    num[5] = cofactor(c, d, a, f);
    num[6] = cofactor(d, h, e, g);
    num[7] = cofactor(b, g, a, h);
    num[8] = cofactor(a, e, b, d);
    num[9] = e * cofactor(g, l, i, j) + f * cofactor(h, j, g, k) - d * cofactor(h, l, i, k);
    num[10] = a * cofactor(h, l, i, k) + b * cofactor(i, j, g, l) + c * cofactor(g, k, h, j);
    num[11] = b * cofactor(d, l, f, j) + c * cofactor(e, j, d, k) - a * cofactor(e, l, f, k);
    det = a * num[0] + b * num[3] + c * num[6];
    sing = (det == 0);
    for (int n = 0; n < 4; n++) begin
      grp.grp  = 2'(n);
      grp.sing = sing;
      grp.last = (2'(n) == GRP_TRANS);
      grp.x = sing ? '0 : scaled_quotient(num[n*3],   det, (n < 3) ? 32 : 16);
      grp.y = sing ? '0 : scaled_quotient(num[n*3+1], det, (n < 3) ? 32 : 16);
      grp.z = sing ? '0 : scaled_quotient(num[n*3+2], det, (n < 3) ? 32 : 16);
      inverse_expect_q.push_back(grp);
    end
  endtask

  // random transform: mostly well conditioned, some full range, some rank deficient
  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 99);
    for (int n = 0; n < 12; n++) begin
      if (kind < 60) m.e[n] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      else if (kind < 75) m.e[n] = $signed($urandom_range(0, 32'h0000_0400)) - 32'sh200;
      else m.e[n] = $urandom;
    end
    if (kind < 60) begin
      // diagonal bias keeps det away from zero
      m.e[0] = m.e[0] + 32'sh0006_0000;
      m.e[4] = m.e[4] + 32'sh0006_0000;
      m.e[8] = m.e[8] + 32'sh0006_0000;
    end
    if (kind >= 94) for (int n = 0; n < 3; n++) m.e[6+n] = m.e[n];
    return m;
  endfunction

  function automatic matrix_t diag_matrix(elem_t v, elem_t t);
    matrix_t m;
    for (int n = 0; n < 12; n++) m.e[n] = (n >= 9) ? t : '0;
    m.e[0] = v; m.e[4] = v; m.e[8] = v;
    return m;
  endfunction

  // request driver
  always @(posedge clk) begin
    logic taken;
    matrix_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        for (int n = 0; n < 12; n++) nxt.e[n] = in_e[n];
        predict_inverse(nxt);
        sent_cnt++;
      end
      if (push && !taken) begin
        // hold current request
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (sent_cnt < QUIET_REQ && $urandom_range(0, 15) == 0) begin
        tx_gap = $urandom_range(1, 15) - 1;
        push <= 1'b0;
      end else if (pending_matrices.size() > 0) begin
        nxt = pending_matrices.pop_front();
        for (int n = 0; n < 12; n++) in_e[n] <= nxt.e[n];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    group_t ex;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        recv_cnt++;
        if (inverse_expect_q.size() == 0) begin
          $display("%0t: unexpected result group %0d", $time, out_group_index);
          errors++;
        end else begin
          ex = inverse_expect_q.pop_front();
          if (out_group_index !== ex.grp) begin
            $display("%0t: group_index exp %0d got %0d", $time, ex.grp, out_group_index);
            errors++;
          end
          if (out_x !== ex.x) begin
            $display("%0t: out_x exp %h got %h", $time, ex.x, out_x);
            errors++;
          end
          if (out_y !== ex.y) begin
            $display("%0t: out_y exp %h got %h", $time, ex.y, out_y);
            errors++;
          end
          if (out_z !== ex.z) begin
            $display("%0t: out_z exp %h got %h", $time, ex.z, out_z);
            errors++;
          end
          if (out_singular !== ex.sing) begin
            $display("%0t: singular exp %b got %b", $time, ex.sing, out_singular);
            errors++;
          end
          if (out_last !== ex.last) begin
            $display("%0t: last exp %b got %b", $time, ex.last, out_last);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up into the request side
      if (!hold_done && recv_cnt >= 40) begin
        hold_done = 1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (recv_cnt < 4 * QUIET_REQ && $urandom_range(0, 15) == 0) begin
        rx_gap = $urandom_range(1, 15) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    // directed: identity, zero, extremes, saturation, negative det, rank deficient
    pending_matrices.push_back(diag_matrix(32'sh0001_0000, 32'sh0000_0000));
    pending_matrices.push_back(diag_matrix(32'sh0001_0000, 32'sh7fff_ffff));
    pending_matrices.push_back(diag_matrix(32'sh0000_0000, 32'sh0001_0000));
    pending_matrices.push_back(diag_matrix(32'sh7fff_ffff, 32'sh8000_0000));
    pending_matrices.push_back(diag_matrix(32'sh8000_0000, 32'sh7fff_ffff));
    pending_matrices.push_back(diag_matrix(32'sh0000_0001, 32'sh0000_0001));
    pending_matrices.push_back(diag_matrix(32'sh0000_0001, 32'sh8000_0000));
    pending_matrices.push_back(diag_matrix(-32'sh0001_0000, 32'sh0002_8000));
    pending_matrices.push_back(diag_matrix(32'sh0003_0000, 32'sh0001_0000));
    pending_matrices.push_back(diag_matrix(32'sh0002_0000, -32'sh0000_0001));
    pending_matrices.push_back(diag_matrix(32'shffff_ffff, 32'sh0000_0003));
    begin
      matrix_t m;
      for (int n = 0; n < 12; n++) m.e[n] = 32'sh7fff_ffff;
      pending_matrices.push_back(m);
      for (int n = 0; n < 12; n++) m.e[n] = 32'sh8000_0000;
      pending_matrices.push_back(m);
      for (int n = 0; n < 12; n++) m.e[n] = n[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      pending_matrices.push_back(m);
      m = diag_matrix(32'sh0001_0000, 32'sh0000_0000);
      m.e[3] = 32'sh0001_0000; m.e[1] = 32'sh0001_0000;
      pending_matrices.push_back(m);
    end
    while (pending_matrices.size() < TOTAL_REQ) pending_matrices.push_back(random_matrix());
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_matrices.size() > 0 || push || inverse_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && inverse_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
